### src/clstat_pkg.sv
package clstat_pkg;

  localparam int DIM_W    = 13;
  localparam int GRID_W   = 8;
  localparam int ROW_W    = 7;
  localparam int SUM_W    = 34;
  localparam int CNT_W    = 25;
  localparam int PIX_W    = 10;
  localparam int ROW_LIMIT = 128;
  localparam int MAX_FRAME_DIM = 4096;
  localparam int MAX_GRID_COLS = 128;

  localparam logic [6:0] LUM_MAX = 7'd100;

  localparam logic [2:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_GRID_COLS      = 3'd2;
  localparam logic [2:0] CFG_GRID_ROWS      = 3'd3;
  localparam logic [2:0] CFG_DARK_THRESHOLD = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } clstat_in_t;

  typedef struct packed {
    logic [6:0] cell_col;
    logic [6:0] cell_row;
    logic [6:0] lum_key;
    logic [9:0] dark_average;
    logic [9:0] light_average;
  } clstat_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]  fw;
    logic [DIM_W-1:0]  fh;
    logic [GRID_W-1:0] gc;
    logic [GRID_W-1:0] gr;
    logic [7:0]        thr;
  } clstat_geom_t;

  typedef struct packed {
    logic [GRID_W-1:0] cx;
    logic [ROW_W-1:0]  cy;
    logic              first;
    logic              last;
    logic [PIX_W-1:0]  sum;
    logic              dark;
  } clstat_job_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_all;
    logic [SUM_W-1:0] sum_dark;
    logic [CNT_W-1:0] dark_count;
    logic [CNT_W-1:0] light_count;
  } clstat_acc_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHK,
    F_MUL,
    F_DIV,
    F_EMIT
  } clstat_fstate_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_UPD,
    B_PREP,
    B_DIV,
    B_DONE
  } clstat_bstate_t;

endpackage

### src/clstat_fifo.sv
module clstat_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  clstat_pkg::clstat_job_t push_data,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output clstat_pkg::clstat_job_t head
);

  clstat_pkg::clstat_job_t slot_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 2'd1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 3'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/clstat_front.sv
module clstat_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  clstat_pkg::clstat_geom_t geom,
  input  logic                     cfg_touch,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  clstat_pkg::clstat_in_t   in_data,
  output logic                     push,
  input  logic                     q_full,
  output clstat_pkg::clstat_job_t  job
);

  typedef struct packed {
    logic [7:0]  c;
    logic [12:0] r;
    logic        ok;
  } adv_t;

  function automatic adv_t adv(input logic [7:0] c, input logic [12:0] r,
                               input logic [7:0] g, input logic [12:0] len);
    adv_t        a;
    logic [13:0] t;
    logic [13:0] t2;
    t  = {1'b0, r} + 14'(g);
    t2 = t - {1'b0, len};
    a.c  = c;
    a.r  = r;
    a.ok = 1'b0;
    if (t < {1'b0, len}) begin
      a.r  = t[12:0];
      a.ok = 1'b1;
    end else if (t2 < {1'b0, len}) begin
      a.c  = c + 8'd1;
      a.r  = t2[12:0];
      a.ok = 1'b1;
    end
    return a;
  endfunction

  clstat_pkg::clstat_fstate_t state_r, state_nxt;
  logic [12:0] x_r, x_nxt, y_r, y_nxt;
  logic [7:0]  cx_r, cx_nxt;
  logic [6:0]  cy_r, cy_nxt;
  logic [12:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic        xv_r, xv_nxt, yv_r, yv_nxt;
  logic [9:0]  s_r, s_nxt;
  logic        dark_r, dark_nxt;
  logic        dsel_r, dsel_nxt;
  logic [21:0] rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [7:0]  q_r, q_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  logic [12:0] x0, y0;
  logic [9:0]  s_in;
  logic        ge;
  logic [21:0] rem_step;
  logic [7:0]  q_step;
  logic [12:0] p_sel, len_sel;
  logic [7:0]  g_sel;
  logic        last_col, last_row;
  adv_t        ax, ay;

  always_comb begin
    s_in     = 10'(in_data.red) + 10'(in_data.green) + 10'(in_data.blue);
    ge       = (rem_r >= dsh_r);
    rem_step = ge ? rem_r - dsh_r : rem_r;
    q_step   = {q_r[6:0], ge};
    p_sel    = dsel_r ? y_r : x_r;
    g_sel    = dsel_r ? geom.gr : geom.gc;
    len_sel  = dsel_r ? geom.fh : geom.fw;
    last_col = ({1'b0, x_r} + 14'd1 >= {1'b0, geom.fw})
            || ({1'b0, rx_r} + 14'(geom.gc) >= {1'b0, geom.fw});
    last_row = ({1'b0, y_r} + 14'd1 >= {1'b0, geom.fh})
            || ({1'b0, ry_r} + 14'(geom.gr) >= {1'b0, geom.fh});
    ax = adv(cx_r, rx_r, geom.gc, geom.fw);
    ay = adv({1'b0, cy_r}, ry_r, geom.gr, geom.fh);

    job.cx    = cx_r;
    job.cy    = cy_r;
    job.first = (rx_r < 13'(geom.gc)) && (ry_r < 13'(geom.gr));
    job.last  = last_col && last_row;
    job.sum   = s_r;
    job.dark  = dark_r;

    state_nxt = state_r;
    x_nxt = x_r;  y_nxt = y_r;
    cx_nxt = cx_r; cy_nxt = cy_r;
    rx_nxt = rx_r; ry_nxt = ry_r;
    xv_nxt = xv_r; yv_nxt = yv_r;
    s_nxt = s_r;  dark_nxt = dark_r;
    dsel_nxt = dsel_r;
    rem_nxt = rem_r; dsh_nxt = dsh_r; q_nxt = q_r; cnt_nxt = cnt_r;
    x0 = x_r;
    y0 = y_r;
    in_ready = 1'b0;
    push     = 1'b0;

    case (state_r)
      clstat_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          s_nxt    = s_in;
          dark_nxt = (s_in < 10'(geom.thr) * 10'd3);
          if (in_data.frame_start) begin
            x0 = '0;
            y0 = '0;
            xv_nxt = 1'b1; yv_nxt = 1'b1;
            cx_nxt = '0; rx_nxt = '0;
            cy_nxt = '0; ry_nxt = '0;
          end
          if (x0 >= geom.fw) begin
            x0 = '0;
            xv_nxt = 1'b1;
            cx_nxt = '0; rx_nxt = '0;
            y0 = y0 + 13'd1;
            yv_nxt = 1'b0;
          end
          if (y0 >= geom.fh) begin
            y0 = '0;
            yv_nxt = 1'b1;
            cy_nxt = '0; ry_nxt = '0;
          end
          x_nxt = x0;
          y_nxt = y0;
          state_nxt = clstat_pkg::F_CHK;
        end
      end
      clstat_pkg::F_CHK: begin
        if (!xv_r) begin
          dsel_nxt  = 1'b0;
          state_nxt = clstat_pkg::F_MUL;
        end else if (!yv_r) begin
          dsel_nxt  = 1'b1;
          state_nxt = clstat_pkg::F_MUL;
        end else begin
          state_nxt = clstat_pkg::F_EMIT;
        end
      end
      clstat_pkg::F_MUL: begin
        rem_nxt   = 22'(p_sel) * 22'(g_sel);
        dsh_nxt   = 22'(len_sel) << 7;
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = clstat_pkg::F_DIV;
      end
      clstat_pkg::F_DIV: begin
        rem_nxt = rem_step;
        dsh_nxt = dsh_r >> 1;
        q_nxt   = q_step;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          if (dsel_r) begin
            cy_nxt = q_step[6:0];
            ry_nxt = rem_step[12:0];
            yv_nxt = 1'b1;
          end else begin
            cx_nxt = q_step;
            rx_nxt = rem_step[12:0];
            xv_nxt = 1'b1;
          end
          state_nxt = clstat_pkg::F_CHK;
        end
      end
      clstat_pkg::F_EMIT: begin
        if (!q_full) begin
          push = 1'b1;
          if ({1'b0, x_r} + 14'd1 >= {1'b0, geom.fw}) begin
            x_nxt = '0; cx_nxt = '0; rx_nxt = '0; xv_nxt = 1'b1;
            if ({1'b0, y_r} + 14'd1 >= {1'b0, geom.fh}) begin
              y_nxt = '0; cy_nxt = '0; ry_nxt = '0; yv_nxt = 1'b1;
            end else begin
              y_nxt  = y_r + 13'd1;
              cy_nxt = ay.c[6:0];
              ry_nxt = ay.r;
              yv_nxt = ay.ok;
            end
          end else begin
            x_nxt  = x_r + 13'd1;
            cx_nxt = ax.c;
            rx_nxt = ax.r;
            xv_nxt = ax.ok;
          end
          state_nxt = clstat_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = clstat_pkg::F_IDLE;
      end
    endcase

    if (cfg_touch) begin
      xv_nxt = 1'b0;
      yv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clstat_pkg::F_IDLE;
      x_r  <= '0; y_r  <= '0;
      cx_r <= '0; cy_r <= '0;
      rx_r <= '0; ry_r <= '0;
      xv_r <= 1'b1; yv_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      x_r  <= x_nxt;  y_r  <= y_nxt;
      cx_r <= cx_nxt; cy_r <= cy_nxt;
      rx_r <= rx_nxt; ry_r <= ry_nxt;
      xv_r <= xv_nxt; yv_r <= yv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    dark_r <= dark_nxt;
    dsel_r <= dsel_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

### src/clstat_back.sv
module clstat_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  clstat_pkg::clstat_job_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output clstat_pkg::clstat_out_t out_data
);

  localparam int MAX_GRID_COLS = clstat_pkg::MAX_GRID_COLS;
  localparam int IDX_W = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
  localparam int LW    = 47;
  localparam int AW    = 35;

  clstat_pkg::clstat_acc_t mem [MAX_GRID_COLS];
  clstat_pkg::clstat_acc_t rd_r;
  logic [MAX_GRID_COLS-1:0] vld_r, vld_nxt;

  clstat_pkg::clstat_bstate_t state_r, state_nxt;
  clstat_pkg::clstat_job_t job_r, job_nxt;
  clstat_pkg::clstat_acc_t acc_r, acc_nxt, base, acc_new;
  logic [LW-1:0] lnum_r, lnum_nxt, ldsh_r, ldsh_nxt;
  logic [AW-1:0] dnum_r, dnum_nxt, ddsh_r, ddsh_nxt;
  logic [AW-1:0] hnum_r, hnum_nxt, hdsh_r, hdsh_nxt;
  logic [9:0]    lq_r, lq_nxt, dq_r, dq_nxt, hq_r, hq_nxt;
  logic          nzn_r, nzn_nxt, nzd_r, nzd_nxt, nzh_r, nzh_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  clstat_pkg::clstat_out_t out_r, out_nxt;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic             wr_en;
  logic [25:0]      n_all;
  logic             lge, dge, hge;

  assign idx       = IDX_W'(job_r.cx);
  assign rd_idx    = IDX_W'(head.cx);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    base    = (job_r.first || !vld_r[idx]) ? '0 : rd_r;
    acc_new = base;
    acc_new.sum_all = base.sum_all + clstat_pkg::SUM_W'(job_r.sum);
    if (job_r.dark) begin
      acc_new.sum_dark   = base.sum_dark + clstat_pkg::SUM_W'(job_r.sum);
      acc_new.dark_count = base.dark_count + 25'd1;
    end else begin
      acc_new.light_count = base.light_count + 25'd1;
    end
    n_all = 26'(acc_r.dark_count) + 26'(acc_r.light_count);
    lge = (lnum_r >= ldsh_r);
    dge = (dnum_r >= ddsh_r);
    hge = (hnum_r >= hdsh_r);

    state_nxt = state_r;
    job_nxt   = job_r;
    acc_nxt   = acc_r;
    vld_nxt   = vld_r;
    lnum_nxt = lnum_r; ldsh_nxt = ldsh_r;
    dnum_nxt = dnum_r; ddsh_nxt = ddsh_r;
    hnum_nxt = hnum_r; hdsh_nxt = hdsh_r;
    lq_nxt = lq_r; dq_nxt = dq_r; hq_nxt = hq_r;
    nzn_nxt = nzn_r; nzd_nxt = nzd_r; nzh_nxt = nzh_r;
    cnt_nxt = cnt_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    pop   = 1'b0;
    wr_en = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      clstat_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          job_nxt   = head;
          state_nxt = clstat_pkg::B_UPD;
        end
      end
      clstat_pkg::B_UPD: begin
        wr_en        = 1'b1;
        vld_nxt[idx] = 1'b1;
        acc_nxt      = acc_new;
        state_nxt    = job_r.last ? clstat_pkg::B_PREP : clstat_pkg::B_IDLE;
      end
      clstat_pkg::B_PREP: begin
        lnum_nxt = LW'(acc_r.sum_all) * LW'(200) + LW'(n_all) * LW'(765);
        ldsh_nxt = (LW'(n_all) * LW'(1530)) << 9;
        dnum_nxt = AW'(acc_r.sum_dark);
        ddsh_nxt = AW'(acc_r.dark_count) << 9;
        hnum_nxt = AW'(acc_r.sum_all - acc_r.sum_dark);
        hdsh_nxt = AW'(acc_r.light_count) << 9;
        nzn_nxt  = (n_all != '0);
        nzd_nxt  = (acc_r.dark_count != '0);
        nzh_nxt  = (acc_r.light_count != '0);
        lq_nxt = '0; dq_nxt = '0; hq_nxt = '0;
        cnt_nxt   = '0;
        state_nxt = clstat_pkg::B_DIV;
      end
      clstat_pkg::B_DIV: begin
        lnum_nxt = lge ? lnum_r - ldsh_r : lnum_r;
        dnum_nxt = dge ? dnum_r - ddsh_r : dnum_r;
        hnum_nxt = hge ? hnum_r - hdsh_r : hnum_r;
        ldsh_nxt = ldsh_r >> 1;
        ddsh_nxt = ddsh_r >> 1;
        hdsh_nxt = hdsh_r >> 1;
        lq_nxt = {lq_r[8:0], lge};
        dq_nxt = {dq_r[8:0], dge};
        hq_nxt = {hq_r[8:0], hge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd9) begin
          state_nxt = clstat_pkg::B_DONE;
        end
      end
      clstat_pkg::B_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt         = 1'b1;
          out_nxt.cell_col      = job_r.cx[6:0];
          out_nxt.cell_row      = job_r.cy;
          out_nxt.lum_key       = !nzn_r ? '0 :
                                  (lq_r > 10'(clstat_pkg::LUM_MAX)) ? clstat_pkg::LUM_MAX :
                                  lq_r[6:0];
          out_nxt.dark_average  = nzd_r ? dq_r : '0;
          out_nxt.light_average = nzh_r ? hq_r : '0;
          state_nxt             = clstat_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = clstat_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clstat_pkg::B_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    acc_r  <= acc_nxt;
    lnum_r <= lnum_nxt; ldsh_r <= ldsh_nxt;
    dnum_r <= dnum_nxt; ddsh_r <= ddsh_nxt;
    hnum_r <= hnum_nxt; hdsh_r <= hdsh_nxt;
    lq_r <= lq_nxt; dq_r <= dq_nxt; hq_r <= hq_nxt;
    nzn_r <= nzn_nxt; nzd_r <= nzd_nxt; nzh_r <= nzh_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= acc_new;
    end
    if (pop) begin
      rd_r <= mem[rd_idx];
    end
  end

endmodule

### src/cell_luminance_statistics.sv
// The front takes one pixel at a time through its accept, check and emit steps, plus a
// serial division per axis when the position must be re-derived after a register write.
// The back reads and then writes the column memory for each item, and a finished
// cell then holds the back end in its serial divider.
// A 4-item queue parts front and back.
// Reset: rst_n synchronous, active low; accumulator valid bits clear at once, no sweep.
module cell_luminance_statistics (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  clstat_pkg::clstat_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output clstat_pkg::clstat_out_t out_data,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [12:0]             cfg_data
);

  logic [12:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [7:0]  gc_r, gc_nxt, gr_r, gr_nxt, thr_r, thr_nxt;
  clstat_pkg::clstat_geom_t geom;
  clstat_pkg::clstat_job_t  push_job, head_job;
  logic fifo_push, fifo_full, fifo_pop, fifo_empty;

  always_comb begin
    fw_nxt = fw_r; fh_nxt = fh_r; gc_nxt = gc_r; gr_nxt = gr_r; thr_nxt = thr_r;
    if (cfg_we) begin
      case (cfg_index)
        clstat_pkg::CFG_FRAME_WIDTH:    fw_nxt  = cfg_data;
        clstat_pkg::CFG_FRAME_HEIGHT:   fh_nxt  = cfg_data;
        clstat_pkg::CFG_GRID_COLS:      gc_nxt  = cfg_data[7:0];
        clstat_pkg::CFG_GRID_ROWS:      gr_nxt  = cfg_data[7:0];
        clstat_pkg::CFG_DARK_THRESHOLD: thr_nxt = cfg_data[7:0];
        default: begin
        end
      endcase
    end
    geom.fw  = (fw_r == '0) ? 13'd1 :
               (32'(fw_r) > clstat_pkg::MAX_FRAME_DIM) ? 13'(clstat_pkg::MAX_FRAME_DIM) : fw_r;
    geom.fh  = (fh_r == '0) ? 13'd1 :
               (32'(fh_r) > clstat_pkg::MAX_FRAME_DIM) ? 13'(clstat_pkg::MAX_FRAME_DIM) : fh_r;
    geom.gc  = (gc_r == '0) ? 8'd1 :
               (32'(gc_r) > clstat_pkg::MAX_GRID_COLS) ? 8'(clstat_pkg::MAX_GRID_COLS) : gc_r;
    geom.gr  = (gr_r == '0) ? 8'd1 :
               (32'(gr_r) > clstat_pkg::ROW_LIMIT) ? 8'(clstat_pkg::ROW_LIMIT) : gr_r;
    geom.thr = thr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= 13'd1920;
      fh_r  <= 13'd1080;
      gc_r  <= 8'd80;
      gr_r  <= 8'd30;
      thr_r <= 8'd128;
    end else begin
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
      gc_r  <= gc_nxt;
      gr_r  <= gr_nxt;
      thr_r <= thr_nxt;
    end
  end

  clstat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .cfg_touch (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (fifo_push),
    .q_full    (fifo_full),
    .job       (push_job)
  );

  clstat_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (push_job),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .empty     (fifo_empty),
    .head      (head_job)
  );

  clstat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (fifo_empty),
    .head      (head_job),
    .pop       (fifo_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full) else $error("item pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty) else $error("item popped from empty queue");
  a_lum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.lum_key <= clstat_pkg::LUM_MAX) else $error("lum_key above 100");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAME_MAX = 4096;
  localparam int COLS_MAX  = 128;
  localparam int STALL_LIMIT = 20000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  clstat_pkg::clstat_in_t  in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  clstat_pkg::clstat_out_t out_data;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = clstat_pkg::CFG_FRAME_WIDTH;
  logic [12:0]             cfg_data = '0;

  cell_luminance_statistics uut (.*);

  always #10 clk = ~clk;

  clstat_pkg::clstat_in_t  pixel_q[$];
  clstat_pkg::clstat_out_t cell_exp_q[$];
  bit          jitter_on = 1'b1;
  int          errors = 0;
  int          quiet_cycles = 0;

  logic [12:0] m_fw = 13'd1920, m_fh = 13'd1080;
  logic [7:0]  m_gc = 8'd80, m_gr = 8'd30, m_thr = 8'd128;
  logic [63:0] acc_all[COLS_MAX], acc_dark[COLS_MAX], cnt_dark[COLS_MAX], cnt_light[COLS_MAX];
  int unsigned pos_x = 0, pos_y = 0;

  function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned cell_at(int unsigned p, int unsigned cells, int unsigned len);
    longint unsigned c;
    c = (longint'(p) * cells) / len;
    return (c >= cells) ? cells - 1 : int'(c);
  endfunction

  task automatic predict_pixel(clstat_pkg::clstat_in_t px);
    int unsigned fw, fh, gc, gr, s, x, y, cx, cy;
    bit f_col, f_row, l_col, l_row;
    longint unsigned n, lsum, lum, dav, lav;
    clstat_pkg::clstat_out_t r;
    fw = clip_dim(m_fw, FRAME_MAX);
    fh = clip_dim(m_fh, FRAME_MAX);
    gc = clip_dim(m_gc, COLS_MAX);
    gr = clip_dim(m_gr, 128);
    s = px.red + px.green + px.blue;
    if (px.frame_start) begin
      pos_x = 0;
      pos_y = 0;
    end
    if (pos_x >= fw) begin
      pos_x = 0;
      pos_y++;
    end
    if (pos_y >= fh) pos_y = 0;
    x = pos_x;
    y = pos_y;
    cx = cell_at(x, gc, fw);
    cy = cell_at(y, gr, fh);
    f_col = (x == 0) || (cell_at(x - 1, gc, fw) != cx);
    f_row = (y == 0) || (cell_at(y - 1, gr, fh) != cy);
    l_col = (x + 1 >= fw) || (cell_at(x + 1, gc, fw) != cx);
    l_row = (y + 1 >= fh) || (cell_at(y + 1, gr, fh) != cy);
    if (f_col && f_row) begin
      acc_all[cx] = 0;
      acc_dark[cx] = 0;
      cnt_dark[cx] = 0;
      cnt_light[cx] = 0;
    end
    acc_all[cx] += s;
    if (s / 3 < m_thr) begin
      acc_dark[cx] += s;
      cnt_dark[cx]++;
    end else begin
      cnt_light[cx]++;
    end
    if (l_col && l_row) begin
      n = cnt_dark[cx] + cnt_light[cx];
      lsum = acc_all[cx] - acc_dark[cx];
      lum = 0;
      dav = 0;
      lav = 0;
      if (n != 0) begin
        lum = (acc_all[cx] * 200 + 765 * n) / (1530 * n);
        if (lum > 100) lum = 100;
      end
      if (cnt_dark[cx] != 0) dav = acc_dark[cx] / cnt_dark[cx];
      if (cnt_light[cx] != 0) lav = lsum / cnt_light[cx];
      r.cell_col = cx[6:0];
      r.cell_row = cy[6:0];
      r.lum_key = lum[6:0];
      r.dark_average = dav[9:0];
      r.light_average = lav[9:0];
      cell_exp_q.push_back(r);
    end
    pos_x = x + 1;
    if (pos_x >= fw) begin
      pos_x = 0;
      pos_y = y + 1;
      if (pos_y >= fh) pos_y = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() > 0 && !(jitter_on && $urandom_range(99) < 21)) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_ready <= !(jitter_on && $urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_pixel(in_data);
      if (out_valid && out_ready) begin
        if (cell_exp_q.size() == 0) begin
          $display("%0t: unexpected cell result %p", $time, out_data);
          errors++;
        end else if (out_data !== cell_exp_q[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, cell_exp_q[0], out_data);
          errors++;
          void'(cell_exp_q.pop_front());
        end else begin
          void'(cell_exp_q.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      clstat_pkg::CFG_FRAME_WIDTH:    m_fw = val;
      clstat_pkg::CFG_FRAME_HEIGHT:   m_fh = val;
      clstat_pkg::CFG_GRID_COLS:      m_gc = val[7:0];
      clstat_pkg::CFG_GRID_ROWS:      m_gr = val[7:0];
      clstat_pkg::CFG_DARK_THRESHOLD: m_thr = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    wait (pixel_q.size() == 0);
    @(posedge clk);
    while (in_valid || cell_exp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_geometry(int fw, int fh, int gc, int gr, int thr);
    drain();
    write_reg(clstat_pkg::CFG_FRAME_WIDTH, 13'(fw));
    write_reg(clstat_pkg::CFG_FRAME_HEIGHT, 13'(fh));
    write_reg(clstat_pkg::CFG_GRID_COLS, 13'(gc));
    write_reg(clstat_pkg::CFG_GRID_ROWS, 13'(gr));
    write_reg(clstat_pkg::CFG_DARK_THRESHOLD, 13'(thr));
  endtask

  task automatic push_pixel(int r, int g, int b, bit fs);
    clstat_pkg::clstat_in_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    p.frame_start = fs;
    pixel_q.push_back(p);
  endtask

  task automatic push_random(int count, int fs_pct);
    repeat (count) push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                              $urandom_range(99) < fs_pct);
  endtask

  initial begin
    int fw, fh;
    for (int i = 0; i < COLS_MAX; i++) begin
      acc_all[i] = 0;
      acc_dark[i] = 0;
      cnt_dark[i] = 0;
      cnt_light[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    push_pixel(255, 255, 255, 1'b1);
    push_pixel(0, 0, 0, 1'b0);
    push_pixel(170, 85, 0, 1'b0);
    set_geometry(4, 4, 2, 2, 128);
    push_pixel(0, 0, 0, 1'b1);
    push_pixel(255, 255, 255, 1'b0);
    push_pixel(127, 128, 128, 1'b0);
    push_pixel(128, 128, 128, 1'b0);
    push_pixel(85, 170, 255, 1'b0);
    push_pixel(255, 0, 0, 1'b0);
    push_pixel(0, 255, 0, 1'b0);
    push_pixel(0, 0, 255, 1'b0);
    push_random(8, 0);
    push_random(6, 0);
    push_pixel(1, 2, 3, 1'b1);
    set_geometry(0, 0, 0, 0, 0);
    push_random(6, 30);
    set_geometry(3, 2, 7, 9, 255);
    push_random(12, 10);
    set_geometry(13'h1FFF, 13'h1FFF, 255, 255, 100);
    push_random(150, 0);
    set_geometry(5, 3, 2, 2, 60);
    push_random(7, 0);
    drain();
    write_reg(clstat_pkg::CFG_FRAME_WIDTH, 13'd2);
    write_reg(clstat_pkg::CFG_FRAME_HEIGHT, 13'd2);
    push_random(10, 0);
    for (int ph = 0; ph < 10; ph++) begin
      fw = $urandom_range(1, 12);
      fh = $urandom_range(1, 8);
      set_geometry(fw, fh, $urandom_range(1, fw + 2), $urandom_range(1, fh + 2),
                   (ph == 3) ? 0 : (ph == 4) ? 255 : $urandom_range(255));
      jitter_on = (ph != 5);
      push_random(75, (ph % 3 == 0) ? 4 : 0);
    end
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### cell_luminance_statistics.f
src/clstat_pkg.sv
src/clstat_fifo.sv
src/clstat_front.sv
src/clstat_back.sv
src/cell_luminance_statistics.sv
test/tb_top.sv
